### rtl/frp_pkg.sv
`timescale 1ns / 1ps

package frp_pkg;

   localparam int TS_W              = 32;
   localparam int SLEEP_W           = 10;
   localparam int FPS_W             = 19;
   localparam int LIMIT_W           = 16;
   localparam int CSR_DATA_W        = 16;
   localparam int CSR_INDEX_W       = 2;
   localparam int BASE_W            = 10;
   localparam int BASE_NUM          = 1000;
   localparam int FPS_SCALE         = 16000;
   localparam int DEF_WINDOW_FRAMES = 32;

   localparam logic [FPS_W-1:0]   IDLE_FPS_X16 = FPS_W'(15984);
   localparam logic [FPS_W-1:0]   FPS_X16_MAX  = FPS_W'(524287);
   localparam logic [LIMIT_W-1:0] FG_RESET     = LIMIT_W'(60);
   localparam logic [LIMIT_W-1:0] BG_RESET     = LIMIT_W'(30);
   localparam logic [LIMIT_W-1:0] LOOK_RESET   = LIMIT_W'(0);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FG_MAX_FPS,
      CSR_BG_MAX_FPS,
      CSR_LOOK_MAX_FPS,
      CSR_COMPENSATE_MODE
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic short_div;
   } frp_div_ctl_type;

endpackage

### rtl/frp_if.sv
`timescale 1ns / 1ps

interface frp_req_if;
   import frp_pkg::*;
   logic            valid;
   logic            ready;
   logic [TS_W-1:0] timestamp_ms;
   logic            in_foreground;
   logic            mouse_look;

   modport source (output valid, timestamp_ms, in_foreground, mouse_look, input ready);
   modport sink   (input valid, timestamp_ms, in_foreground, mouse_look, output ready);
endinterface

interface frp_rsp_if;
   import frp_pkg::*;
   logic               valid;
   logic               ready;
   logic [SLEEP_W-1:0] sleep_ms;
   logic [TS_W-1:0]    frame_time_ms;
   logic [FPS_W-1:0]   fps_x16;

   modport source (output valid, sleep_ms, frame_time_ms, fps_x16, input ready);
   modport sink   (input valid, sleep_ms, frame_time_ms, fps_x16, output ready);
endinterface

### rtl/frame_rate_pacer.sv
`timescale 1ns / 1ps
// Flow: accept, read the previous and first stamps, start the divider, divide for the rate,
// then divide for the sleep base (skipped with a zero limit), then the output register; with
// all limits zero an item goes straight to the output register. The next item is taken once
// the last is in the output register. The bit-serial divider is shared by the rate quotient
// (NUM_W bits) and the sleep base 1000/limit (10 bits).
// Reset: synchronous, active high; limits 60/30/0, compensation on, ring empty.
module frame_rate_pacer #(
   parameter int WINDOW_FRAMES = frp_pkg::DEF_WINDOW_FRAMES
) (
   input  logic                            clock,
   input  logic                            reset,
   frp_req_if.sink                         req_ch,
   frp_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [frp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [frp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import frp_pkg::*;

   localparam int DEPTH = WINDOW_FRAMES + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int NUM_W = $clog2(WINDOW_FRAMES * FPS_SCALE + 1);
   localparam int QX_W  = (NUM_W > FPS_W) ? NUM_W : FPS_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_FRAMES);

   typedef enum logic [2:0] {
      S_IDLE, S_RD_PREV, S_RD_FIRST, S_START, S_DIV_FPS, S_DIV_BASE, S_OUT
   } state_type;

   state_type          state_ff;
   logic [LIMIT_W-1:0] fg_max_ff, bg_max_ff, look_max_ff;
   logic               comp_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               full_ff;
   logic [SLEEP_W-1:0] prior_ff;

   logic [TS_W-1:0]    now_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               ezero_ff;
   logic [TS_W-1:0]    ft_ff;
   logic [FPS_W-1:0]   fps_ff;
   logic [SLEEP_W-1:0] sleep_ff;

   logic               rsp_valid_ff;
   logic [SLEEP_W-1:0] rsp_sleep_ff;
   logic [TS_W-1:0]    rsp_ft_ff;
   logic [FPS_W-1:0]   rsp_fps_ff;

   logic [TS_W-1:0]    ring [DEPTH];
   logic [TS_W-1:0]    mem_q_ff;
   logic [IDX_W-1:0]   mem_ra, mem_wa;
   logic               mem_we;

   logic [IDX_W-1:0]   prev_idx, first_idx, idx_in;
   logic [TS_W-1:0]    diff;
   logic [NUM_W-1:0]   fps_numer;
   logic [LIMIT_W-1:0] limit_in;
   logic               block_off, req_take, rsp_free;

   frp_div_ctl_type    div_ctl;
   logic [NUM_W-1:0]   div_numer;
   logic [TS_W-1:0]    div_denom;
   logic               div_busy;
   logic [NUM_W-1:0]   div_quot;

   logic [QX_W-1:0]    q_ext;
   logic [FPS_W-1:0]   fps_in;
   logic [BASE_W-1:0]  base;
   logic [BASE_W:0]    budget, slack;
   logic               overrun, reseed;
   logic [SLEEP_W-1:0] sleep_in;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid & req_ch.ready;
   assign rsp_free     = ~rsp_valid_ff | rsp_ch.ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.sleep_ms      = rsp_sleep_ff;
   assign rsp_ch.frame_time_ms = rsp_ft_ff;
   assign rsp_ch.fps_x16       = rsp_fps_ff;

   assign block_off = (fg_max_ff == '0) & (bg_max_ff == '0) & (look_max_ff == '0);
   assign limit_in  = req_ch.in_foreground ?
                      (req_ch.mouse_look ? look_max_ff : fg_max_ff) : bg_max_ff;

   assign prev_idx  = (idx_ff == '0) ? LAST_IDX : idx_ff - 1'b1;
   assign first_idx = ~full_ff ? '0 : ((idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1);
   assign idx_in    = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign mem_ra    = (state_ff == S_RD_PREV) ? prev_idx : first_idx;

   // empty ring at slot zero: no previous frame and a zero window
   assign diff = (idx_ff == '0 && !full_ff) ? '0 : now_ff - mem_q_ff;

   assign fps_numer = (full_ff ? NUM_W'(WINDOW_FRAMES) : NUM_W'(idx_ff)) * NUM_W'(FPS_SCALE);

   assign q_ext  = QX_W'(div_quot);
   assign fps_in = ezero_ff ? IDLE_FPS_X16 :
                   (q_ext > QX_W'(FPS_X16_MAX)) ? FPS_X16_MAX : q_ext[FPS_W-1:0];

   assign base    = div_quot[BASE_W-1:0];
   assign budget  = {1'b0, base} + {1'b0, prior_ff};
   assign overrun = (ft_ff >= TS_W'(budget));
   assign slack   = budget - ft_ff[BASE_W:0];
   // a zero base caps every compensated sleep to zero
   assign reseed  = comp_ff & (overrun | (base == '0));
   always_comb begin
      if (!comp_ff) begin
         sleep_in = base;
      end else if (overrun) begin
         sleep_in = '0;
      end else if (slack > {1'b0, base}) begin
         sleep_in = base;
      end else begin
         sleep_in = slack[SLEEP_W-1:0];
      end
   end

   always_comb begin
      div_ctl   = '0;
      div_numer = fps_numer;
      div_denom = diff;
      if (state_ff == S_START) begin
         div_ctl.start = 1'b1;
      end else if (state_ff == S_DIV_FPS && !div_busy && limit_ff != '0) begin
         div_ctl.start     = 1'b1;
         div_ctl.short_div = 1'b1;
         div_numer         = NUM_W'(BASE_NUM);
         div_denom         = TS_W'(limit_ff);
      end
   end

   assign mem_we = (state_ff == S_START) | (state_ff == S_DIV_BASE && !div_busy && reseed);
   assign mem_wa = (state_ff == S_START) ? idx_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring[mem_wa] <= now_ff;
      end
      mem_q_ff <= ring[mem_ra];
   end

   frp_div #(.NUM_W(NUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .numer (div_numer),
      .denom (div_denom),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_max_ff   <= FG_RESET;
         bg_max_ff   <= BG_RESET;
         look_max_ff <= LOOK_RESET;
         comp_ff     <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FG_MAX_FPS:      fg_max_ff   <= csr_wdata[LIMIT_W-1:0];
            CSR_BG_MAX_FPS:      bg_max_ff   <= csr_wdata[LIMIT_W-1:0];
            CSR_LOOK_MAX_FPS:    look_max_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_COMPENSATE_MODE: comp_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         full_ff      <= 1'b0;
         prior_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  now_ff   <= req_ch.timestamp_ms;
                  limit_ff <= limit_in;
                  if (block_off) begin
                     ft_ff    <= '0;
                     fps_ff   <= '0;
                     sleep_ff <= '0;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_RD_PREV;
                  end
               end
            end
            S_RD_PREV: begin
               state_ff <= S_RD_FIRST;
            end
            S_RD_FIRST: begin
               ft_ff    <= diff;
               state_ff <= S_START;
            end
            S_START: begin
               ezero_ff <= (diff == '0);
               idx_ff   <= idx_in;
               if (idx_ff == LAST_IDX) begin
                  full_ff <= 1'b1;
               end
               state_ff <= S_DIV_FPS;
            end
            S_DIV_FPS: begin
               if (!div_busy) begin
                  fps_ff <= fps_in;
                  if (limit_ff == '0) begin
                     sleep_ff <= '0;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_DIV_BASE;
                  end
               end
            end
            S_DIV_BASE: begin
               if (!div_busy) begin
                  sleep_ff <= sleep_in;
                  prior_ff <= sleep_in;
                  if (reseed) begin
                     idx_ff  <= IDX_W'(1);
                     full_ff <= 1'b0;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_sleep_ff <= sleep_ff;
                  rsp_ft_ff    <= ft_ff;
                  rsp_fps_ff   <= fps_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### rtl/frp_div.sv
`timescale 1ns / 1ps

module frp_div #(
   parameter int NUM_W = 22
) (
   input  logic                      clock,
   input  logic                      reset,
   input  frp_pkg::frp_div_ctl_type  ctl,
   input  logic [NUM_W-1:0]          numer,
   input  logic [frp_pkg::TS_W-1:0]  denom,
   output logic                      busy,
   output logic [NUM_W-1:0]          quot
);
   import frp_pkg::*;

   localparam int CNT_W       = $clog2(NUM_W + 1);
   localparam int SHORT_SHIFT = NUM_W - BASE_W;

   logic [NUM_W-1:0] num_ff;
   logic [TS_W-1:0]  rem_ff;
   logic [TS_W-1:0]  den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [TS_W:0]    trial;
   logic             fits;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, num_ff[NUM_W-1]} - {1'b0, den_ff};
   assign fits  = ~trial[TS_W];
   assign busy  = (cnt_ff != '0);
   assign quot  = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctl.start) begin
         num_ff <= ctl.short_div ? (numer << SHORT_SHIFT) : numer;
         rem_ff <= '0;
         den_ff <= denom;
         cnt_ff <= ctl.short_div ? CNT_W'(BASE_W) : CNT_W'(NUM_W);
      end else if (busy) begin
         rem_ff <= fits ? trial[TS_W-1:0] : {rem_ff[TS_W-2:0], num_ff[NUM_W-1]};
         num_ff <= {num_ff[NUM_W-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

### tb/sv/frame_rate_pacer_tb.sv
`timescale 1ns / 1ps

module frame_rate_pacer_tb;
   import frp_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE      = 60;
   localparam int STARVE      = 300;

   typedef struct packed {
      logic [TS_W-1:0] stamp;
      logic            fg;
      logic            look;
   } frame_type;

   typedef struct packed {
      logic [SLEEP_W-1:0] sleep_ms;
      logic [TS_W-1:0]    frame_time_ms;
      logic [FPS_W-1:0]   fps_x16;
   } pacing_type;

   class pacing_scoreboard;
      logic [LIMIT_W-1:0] fg_limit;
      logic [LIMIT_W-1:0] bg_limit;
      logic [LIMIT_W-1:0] look_limit;
      logic               compensate;
      logic [TS_W-1:0]    stamps [DEF_WINDOW_FRAMES+1];
      int unsigned        slot;
      bit                 wrapped;
      logic [10:0]        prior_sleep;
      pacing_type         pending [$];
      int                 errors;
      int                 frames_seen;
      int                 results_seen;
      int                 reseeds;
      int                 off_frames;

      function new();
         fg_limit    = FG_RESET;
         bg_limit    = BG_RESET;
         look_limit  = LOOK_RESET;
         compensate  = 1'b1;
         foreach (stamps[i]) stamps[i] = '0;
         slot        = 0;
         wrapped     = 1'b0;
         prior_sleep = '0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FG_MAX_FPS:      fg_limit   = data;
            CSR_BG_MAX_FPS:      bg_limit   = data;
            CSR_LOOK_MAX_FPS:    look_limit = data;
            CSR_COMPENSATE_MODE: compensate = data[0];
            default: ;
         endcase
      endfunction

      function pacing_type predict_pacing(frame_type f);
         int unsigned        cur;
         int unsigned        first;
         int unsigned        frames;
         int unsigned        written;
         logic [TS_W-1:0]    frame_time;
         logic [TS_W-1:0]    elapsed;
         logic [63:0]        q;
         longint             base;
         longint             s;
         logic [LIMIT_W-1:0] limit;
         pacing_type         r;
         r = '0;
         if (fg_limit == 0 && bg_limit == 0 && look_limit == 0) begin
            off_frames++;
            return r;
         end
         cur = slot;
         stamps[cur] = f.stamp;
         written = cur;
         if (wrapped) begin
            first  = (cur + 1 > DEF_WINDOW_FRAMES) ? 0 : cur + 1;
            frames = DEF_WINDOW_FRAMES;
         end else begin
            first  = 0;
            frames = cur;
         end
         if (cur == 0)
            frame_time = wrapped ? f.stamp - stamps[DEF_WINDOW_FRAMES] : '0;
         else
            frame_time = f.stamp - stamps[cur-1];
         elapsed = f.stamp - stamps[first];
         if (elapsed == 0) begin
            r.fps_x16 = IDLE_FPS_X16;
         end else begin
            q = (64'(frames) * 64'(FPS_SCALE)) / {32'd0, elapsed};
            r.fps_x16 = (q > {45'd0, FPS_X16_MAX}) ? FPS_X16_MAX : q[FPS_W-1:0];
         end
         cur++;
         if (cur > DEF_WINDOW_FRAMES) begin
            cur = 0;
            wrapped = 1'b1;
         end
         slot = cur;
         limit = f.fg ? (f.look ? look_limit : fg_limit) : bg_limit;
         if (limit != 0) begin
            base = BASE_NUM / int'(limit);
            if (compensate) begin
               s = base - longint'({32'd0, frame_time}) + longint'({53'd0, prior_sleep});
               if (s > base) s = base;
               if (s < 1) begin
                  s = 0;
                  stamps[0] = stamps[written];
                  slot = 1;
                  wrapped = 1'b0;
                  reseeds++;
               end
            end else begin
               s = base;
            end
            prior_sleep = s[10:0];
            r.sleep_ms = s[SLEEP_W-1:0];
         end
         r.frame_time_ms = frame_time;
         return r;
      endfunction

      function void note_frame(frame_type f);
         pending.push_back(predict_pacing(f));
         frames_seen++;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("mismatch: %s", msg);
      endtask

      task check_pacing(pacing_type got);
         pacing_type want;
         results_seen++;
         if (pending.size() == 0) begin
            report($sformatf("result %0d with no frame pending (sleep %0d, frame time %0d)",
                             results_seen, got.sleep_ms, got.frame_time_ms));
            return;
         end
         want = pending.pop_front();
         if (got.sleep_ms !== want.sleep_ms)
            report($sformatf("result %0d sleep_ms got %0d want %0d",
                             results_seen, got.sleep_ms, want.sleep_ms));
         if (got.frame_time_ms !== want.frame_time_ms)
            report($sformatf("result %0d frame_time_ms got %0d want %0d",
                             results_seen, got.frame_time_ms, want.frame_time_ms));
         if (got.fps_x16 !== want.fps_x16)
            report($sformatf("result %0d fps_x16 got %0d want %0d",
                             results_seen, got.fps_x16, want.fps_x16));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   frp_req_if req_bus ();
   frp_rsp_if rsp_bus ();

   pacing_scoreboard board = new;

   int              send_idle_pct = 6;
   int              rsp_idle_pct  = 65;
   int              hold_left     = 0;
   int              settings      = 0;
   logic [TS_W-1:0] stamp_now     = '0;

   frame_rate_pacer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: check, then pick ready for the next cycle
   initial begin
      pacing_type got;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{sleep_ms: rsp_bus.sleep_ms, frame_time_ms: rsp_bus.frame_time_ms,
                    fps_x16: rsp_bus.fps_x16};
            board.check_pacing(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_frame(input frame_type f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.timestamp_ms  <= f.stamp;
      req_bus.in_foreground <= f.fg;
      req_bus.mouse_look    <= f.look;
      stamp_now = f.stamp;
      do @(posedge clock); while (!req_bus.ready);
      board.note_frame(f);
   endtask

   task automatic send_stamp(input logic [TS_W-1:0] stamp, input logic fg, input logic look);
      frame_type f;
      f = '{stamp: stamp, fg: fg, look: look};
      send_frame(f);
   endtask

   // mostly paced frames that follow the last sleep, some jumps, stalls and rewinds
   function automatic frame_type pick_frame();
      frame_type   f;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3)
         f.stamp = $urandom;
      else if (roll < 5)
         f.stamp = stamp_now - $urandom_range(1, 5000);
      else if (roll < 8)
         f.stamp = stamp_now + $urandom_range(1000, 200000);
      else if (roll < 11)
         f.stamp = stamp_now;
      else
         f.stamp = stamp_now + board.prior_sleep + $urandom_range(0, 12);
      f.fg   = ($urandom_range(99) < 80);
      f.look = 1'($urandom_range(1));
      return f;
   endfunction

   task automatic run_frames(input int count);
      for (int i = 0; i < count; i++) send_frame(pick_frame());
   endtask

   task automatic drain(input int settle);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.set_reg(idx, data);
   endtask

   task automatic run_segment(input logic [CSR_DATA_W-1:0] fg, input logic [CSR_DATA_W-1:0] bg,
                              input logic [CSR_DATA_W-1:0] look,
                              input logic [CSR_DATA_W-1:0] comp, input int count);
      drain(SETTLE);
      write_reg(CSR_FG_MAX_FPS, fg);
      write_reg(CSR_BG_MAX_FPS, bg);
      write_reg(CSR_LOOK_MAX_FPS, look);
      write_reg(CSR_COMPENSATE_MODE, comp);
      csr_we <= 1'b0;
      settings++;
      run_frames(count);
   endtask

   initial begin
      req_bus.valid         <= 1'b0;
      req_bus.timestamp_ms  <= '0;
      req_bus.in_foreground <= 1'b0;
      req_bus.mouse_look    <= 1'b0;
      csr_we                <= 1'b0;
      csr_index             <= CSR_FG_MAX_FPS;
      csr_wdata             <= '0;
      reset                 <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset limits: fg 60, bg 30, look none, compensating
      send_stamp(32'h0000_0000, 1'b1, 1'b0);
      send_stamp(32'h0000_0010, 1'b1, 1'b0);
      send_stamp(32'h0000_0010, 1'b1, 1'b0);
      send_stamp(32'h0000_0028, 1'b1, 1'b1);
      send_stamp(32'h0000_0049, 1'b0, 1'b0);
      send_stamp(32'h0000_006A, 1'b0, 1'b1);
      send_stamp(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_stamp(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_stamp(32'h0000_000A, 1'b1, 1'b0);
      send_stamp(32'h0000_0005, 1'b1, 1'b0);
      send_stamp(32'h8000_0000, 1'b0, 1'b0);
      send_stamp(32'h8000_0010, 1'b1, 1'b0);
      send_stamp(32'h7FFF_FFFF, 1'b1, 1'b1);

      run_segment(16'd60, 16'd30, 16'd144, 16'h0001, 240);
      run_segment(16'd1, 16'hFFFF, 16'd2, 16'hFFFE, 240);
      drain(0);
      run_frames(100);

      send_idle_pct = 65;
      rsp_idle_pct  = 6;
      run_segment(16'd0, 16'd0, 16'd0, 16'h0001, 60);
      run_segment(16'hFFFF, 16'd1, 16'd1000, 16'h0001, 200);
      run_segment(16'd240, 16'd0, 16'd120, 16'h8001, 240);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      run_segment(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                  16'($urandom_range(1, 300)), 16'($urandom), 240);
      hold_left = STARVE;
      run_frames(24);
      run_segment(16'd144, 16'd20, 16'd0, 16'h0000, 240);
      run_segment(16'd30, 16'hFFFF, 16'd60, 16'h0001, 120);

      drain(SETTLE);
      $display("covered %0d frames under %0d limit settings, both idling mixes and a long stall",
               board.frames_seen, settings);
      $display("%0d ring re-seeds, %0d frames with pacing switched off",
               board.reseeds, board.off_frames);
      if (board.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
